// File: hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
// every macro samples on posedge clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// antecedent this cycle implies consequent in the next cycle
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/pst_pkg.sv
// shared constants, codes and types of the process scheduler tick block
// no dependencies
`timescale 1ns / 1ps

package pst_pkg;

    // sizing
    localparam int MAX_PROCS = 16;
    localparam int TIME_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int REM_W     = 12;
    localparam int PRIO_W    = 8;
    localparam int MODE_W    = 3;
    localparam int SUM_W     = 20;
    localparam int KEY_W     = (TIME_BITS > REM_W) ? TIME_BITS : REM_W;
    localparam int ADD_W     = ((TIME_BITS > SUM_W) ? TIME_BITS : SUM_W) + 1;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [SUM_W-1:0]     SUM_MAX  = '1;

    // scheduling modes
    localparam logic [MODE_W-1:0] MODE_FCFS = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SJF  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SRTF = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LRTF = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PRIO = 3'd4;

    // item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // configuration register indexes
    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    // one process table entry
    typedef struct packed {
        logic [TIME_BITS-1:0] arrive;
        logic [REM_W-1:0]     service;
        logic [PRIO_W-1:0]    prio;
        logic [REM_W-1:0]     rem;
    } entry_t;

    // sequencer to selection unit
    typedef struct packed {
        logic                 start;
        logic                 eval;
        logic [IDX_W-1:0]     idx;
        logic [MODE_W-1:0]    mode;
        logic                 hold_en;
        logic [IDX_W-1:0]     held_idx;
        logic [TIME_BITS-1:0] now;
    } pick_ctrl_t;

    // selection unit to sequencer
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        entry_t           entry;
        logic [CNT_W-1:0] live_cnt;
    } pick_res_t;

endpackage

// File: hw/rtl/pst_table.sv
// process table memory: one write port, one registered read port
// depends on pst_pkg
`timescale 1ns / 1ps

module pst_table (
    input  logic                      clk,
    input  logic                      we,
    input  logic [pst_pkg::IDX_W-1:0] waddr,
    input  pst_pkg::entry_t           wdata,
    input  logic                      re,
    input  logic [pst_pkg::IDX_W-1:0] raddr,
    output pst_pkg::entry_t           rdata
);
    import pst_pkg::*;

    entry_t mem [MAX_PROCS];
    entry_t rdata_reg;

    // synchronous write and read, read data registered and available in the cycle after the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/pst_pick.sv
// selection unit: compares one table entry per cycle against the best so far
// depends on pst_pkg
`timescale 1ns / 1ps

module pst_pick (
    input  logic                clk,
    input  logic                rst_n,
    input  pst_pkg::pick_ctrl_t ctrl,
    input  pst_pkg::entry_t     rdata,
    output pst_pkg::pick_res_t  res
);
    import pst_pkg::*;

    logic             found_reg;
    logic             locked_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] live_reg;
    entry_t           best_reg;

    logic             ready;
    logic             is_held;
    logic             better;
    logic             take;
    logic [KEY_W-1:0] key_new;
    logic [KEY_W-1:0] key_best;

    // sort key of an entry under the current mode
    function automatic logic [KEY_W-1:0] key_of(input logic [MODE_W-1:0] m, input entry_t e);
        logic [KEY_W-1:0] k;
        unique case (m)
            MODE_SJF, MODE_SRTF, MODE_LRTF: k = KEY_W'(e.rem);
            MODE_PRIO:                      k = KEY_W'(e.prio);
            default:                        k = KEY_W'(e.arrive);
        endcase
        return k;
    endfunction

    // readiness and comparison of the entry coming out of the memory
    always_comb
    begin
        ready    = ctrl.eval && (rdata.rem != '0) && (rdata.arrive <= ctrl.now);
        is_held  = ctrl.hold_en && (ctrl.idx == ctrl.held_idx);
        key_new  = key_of(ctrl.mode, rdata);
        key_best = key_of(ctrl.mode, best_reg);
        better   = (ctrl.mode == MODE_LRTF) ? (key_new > key_best) : (key_new < key_best);
        take     = ready && !locked_reg && (is_held || !found_reg || better);
    end

    // running best and count of entries with time left
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg  <= 1'b0;
            locked_reg <= 1'b0;
            idx_reg    <= '0;
            live_reg   <= '0;
        end
        else if (ctrl.start)
        begin
            found_reg  <= 1'b0;
            locked_reg <= 1'b0;
            idx_reg    <= '0;
            live_reg   <= '0;
        end
        else if (ctrl.eval)
        begin
            live_reg <= live_reg + CNT_W'(rdata.rem != '0);
            if (take)
            begin
                found_reg  <= 1'b1;
                locked_reg <= is_held;
                idx_reg    <= ctrl.idx;
            end
        end
    end

    // copy of the chosen entry
    always_ff @(posedge clk)
    begin
        if (ctrl.eval && take)
        begin
            best_reg <= rdata;
        end
    end

    assign res.found    = found_reg;
    assign res.idx      = idx_reg;
    assign res.entry    = best_reg;
    assign res.live_cnt = live_reg;

endmodule

// File: hw/rtl/pst_acct.sv
// completion accounting: saturating turnaround and waiting sums
// depends on pst_pkg
`timescale 1ns / 1ps

module pst_acct (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          upd,
    input  logic [pst_pkg::TIME_BITS-1:0] tat,
    input  logic [pst_pkg::REM_W-1:0]     service,
    output logic [pst_pkg::SUM_W-1:0]     tat_sum,
    output logic [pst_pkg::SUM_W-1:0]     wait_sum
);
    import pst_pkg::*;

    logic [SUM_W-1:0] tat_sum_reg;
    logic [SUM_W-1:0] tat_sum_next;
    logic [SUM_W-1:0] wait_sum_reg;
    logic [SUM_W-1:0] wait_sum_next;
    logic [ADD_W-1:0] tat_x;
    logic [ADD_W-1:0] svc_x;
    logic [ADD_W-1:0] wt_x;
    logic [ADD_W-1:0] tat_acc;
    logic [ADD_W-1:0] wait_acc;

    // waiting is turnaround less service, floored at zero
    always_comb
    begin
        tat_x    = ADD_W'(tat);
        svc_x    = ADD_W'(service);
        wt_x     = (tat_x > svc_x) ? (tat_x - svc_x) : '0;
        tat_acc  = ADD_W'(tat_sum_reg) + tat_x;
        wait_acc = ADD_W'(wait_sum_reg) + wt_x;
        tat_sum_next  = (tat_acc > ADD_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(tat_acc);
        wait_sum_next = (wait_acc > ADD_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(wait_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tat_sum_reg  <= '0;
            wait_sum_reg <= '0;
        end
        else if (upd)
        begin
            tat_sum_reg  <= tat_sum_next;
            wait_sum_reg <= wait_sum_next;
        end
    end

    assign tat_sum  = tat_sum_reg;
    assign wait_sum = wait_sum_reg;

endmodule

// File: hw/rtl/process_scheduler_tick_top.sv
// Load item: written into the table as it is accepted, no result; next item the following cycle.
// Tick item: the table scan reads the n entries in use, one memory read a cycle, then the
// result is committed; no new item is taken until then (n = entries in use, at most 16).
// Result sits in an output register; a waiting result only delays the next tick's commit.
// Reset: mode fcfs, one entry in use, time and sums zero, no hold; table undefined until loaded.
// top level: sequencer, time counter, hold, configuration and result register
// depends on pst_pkg, pst_table, pst_pick, pst_acct
`timescale 1ns / 1ps

module process_scheduler_tick_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [3:0]  slot,
    input  logic [15:0] arrival,
    input  logic [11:0] burst,
    input  logic [7:0]  prio,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  ran_index,
    output logic        idle,
    output logic        finished,
    output logic [15:0] finish_time,
    output logic        all_done,
    output logic [19:0] sum_turnaround,
    output logic [19:0] sum_waiting,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);
    import pst_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [IDX_W-1:0]     issue_reg;
    logic [IDX_W-1:0]     issue_next;
    logic                 eval_reg;
    logic [IDX_W-1:0]     eval_idx_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [4:0]           count_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [IDX_W-1:0]     held_idx_reg;
    logic                 held_valid_reg;
    logic                 out_valid_reg;
    logic [3:0]           ran_index_reg;
    logic                 idle_reg;
    logic                 finished_reg;
    logic [15:0]          finish_time_reg;
    logic                 all_done_reg;

    logic [CNT_W-1:0]     n_use;
    logic                 accept;
    logic                 load_acc;
    logic                 tick_acc;
    logic                 slot_ok;
    logic                 out_free;
    logic                 commit;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    entry_t               wdata;
    entry_t               rdata;
    entry_t               upd_entry;
    logic [REM_W-1:0]     dec_rem;
    logic                 fin;
    logic                 left;
    logic [TIME_BITS-1:0] now_inc;
    logic [TIME_BITS-1:0] tat;
    pick_ctrl_t           pick_ctrl;
    pick_res_t            pick_res;

    // handshake and entries in use
    always_comb
    begin
        n_use    = (32'(count_reg) > MAX_PROCS) ? CNT_W'(MAX_PROCS) : CNT_W'(count_reg);
        in_stall = (state_reg != ST_IDLE);
        accept   = in_valid && !in_stall;
        load_acc = accept && (func == FUNC_LOAD);
        tick_acc = accept && (func == FUNC_TICK);
        slot_ok  = (32'(slot) < MAX_PROCS);
        out_free = !out_valid_reg || !out_stall;
        commit   = (state_reg == ST_UPDATE) && out_free;
    end

    // result of the tick from the chosen entry
    always_comb
    begin
        dec_rem   = pick_res.entry.rem - REM_W'(1);
        fin       = pick_res.found && (dec_rem == '0);
        now_inc   = (now_reg != TIME_MAX) ? (now_reg + TIME_BITS'(1)) : now_reg;
        tat       = now_inc - pick_res.entry.arrive;
        left      = (pick_res.live_cnt - CNT_W'(fin)) != '0;
        upd_entry = pick_res.entry;
        upd_entry.rem = dec_rem;
    end

    // table access: reads on tick acceptance and during the scan, writes on load or commit only,
    // so a write always lands before the next scan reads
    always_comb
    begin
        rd_en   = (tick_acc && (n_use != '0)) || (state_reg == ST_SCAN);
        rd_addr = (state_reg == ST_SCAN) ? issue_reg : '0;
        we      = (load_acc && slot_ok) || (commit && pick_res.found);
        if (load_acc)
        begin
            waddr         = IDX_W'(slot);
            wdata.arrive  = TIME_BITS'(arrival);
            wdata.service = burst;
            wdata.prio    = prio;
            wdata.rem     = burst;
        end
        else
        begin
            waddr = pick_res.idx;
            wdata = upd_entry;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        issue_next = issue_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_acc)
                begin
                    issue_next = IDX_W'(1);
                    if (n_use == '0)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else if (n_use == CNT_W'(1))
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                issue_next = issue_reg + IDX_W'(1);
                if (CNT_W'(issue_reg) == (n_use - CNT_W'(1)))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            issue_reg    <= '0;
            eval_reg     <= 1'b0;
            eval_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            issue_reg    <= issue_next;
            eval_reg     <= rd_en;
            eval_idx_reg <= rd_addr;
        end
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_FCFS;
            count_reg <= 5'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[MODE_W-1:0];
                CFG_COUNT: count_reg <= cfg_data;
            endcase
        end
    end

    // time counter and non-preemptive hold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg        <= '0;
            held_idx_reg   <= '0;
            held_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            now_reg <= now_inc;
            if (pick_res.found)
            begin
                held_idx_reg   <= pick_res.idx;
                held_valid_reg <= !fin;
            end
            else
            begin
                held_valid_reg <= 1'b0;
            end
        end
        else if (load_acc && slot_ok && held_valid_reg && (held_idx_reg == IDX_W'(slot)))
        begin
            held_valid_reg <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            ran_index_reg   <= pick_res.found ? 4'(pick_res.idx) : 4'd0;
            idle_reg        <= !pick_res.found;
            finished_reg    <= fin;
            finish_time_reg <= 16'(now_inc);
            all_done_reg    <= !left;
        end
    end

    // selection unit control
    always_comb
    begin
        pick_ctrl.start    = tick_acc;
        pick_ctrl.eval     = eval_reg;
        pick_ctrl.idx      = eval_idx_reg;
        pick_ctrl.mode     = mode_reg;
        pick_ctrl.hold_en  = ((mode_reg == MODE_SJF) || (mode_reg == MODE_PRIO)) && held_valid_reg;
        pick_ctrl.held_idx = held_idx_reg;
        pick_ctrl.now      = now_reg;
    end

    pst_table u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    pst_pick u_pick (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (pick_ctrl),
        .rdata (rdata),
        .res   (pick_res)
    );

    pst_acct u_acct (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (commit && fin),
        .tat      (tat),
        .service  (pick_res.entry.service),
        .tat_sum  (sum_turnaround),
        .wait_sum (sum_waiting)
    );

    assign out_valid   = out_valid_reg;
    assign ran_index   = ran_index_reg;
    assign idle        = idle_reg;
    assign finished    = finished_reg;
    assign finish_time = finish_time_reg;
    assign all_done    = all_done_reg;

endmodule

// File: hw/rtl/pst_checker.sv
// port-level checks on the scheduler tick block, bound to the top level
// depends on assert_macros.svh and process_scheduler_tick_top
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        func,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  ran_index,
    input logic        idle,
    input logic        finished,
    input logic [19:0] sum_turnaround,
    input logic [19:0] sum_waiting
);

    // a stalled result stays offered
    `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

    // a tick item occupies the block for at least the following cycle
    `CHK_NEXT(a_tick_busy, in_valid && !in_stall && func, in_stall, "tick item did not stall input")

    // a load item leaves the input free in the next cycle
    `CHK_NEXT(a_load_quick, in_valid && !in_stall && !func, !in_stall, "load item stalled input")

    // an idle slot reports no process and no completion
    `CHK_ASSERT(a_idle_result, (out_valid && idle) |-> ((ran_index == 4'd0) && !finished), "idle result carries a process")

    // waiting never exceeds turnaround
    `CHK_ASSERT(a_sum_order, out_valid |-> (sum_waiting <= sum_turnaround), "waiting sum above turnaround sum")

endmodule

bind process_scheduler_tick_top pst_checker u_pst_checker (.*);
